// ----- hdl/sll_pkg.sv -----
package sll_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int IDX_W     = 7;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_DELETE,
        KIND_FIND,
        KIND_REPLACE
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_FOUND,
        ST_BAD_POS
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SEARCH,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR
    } state_t;

endpackage

// ----- hdl/sll_store.sv -----
module sll_store
    import sll_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AW-1:0]    rd_addr,
    input  logic             link_we,
    input  logic [AW-1:0]    link_waddr,
    input  logic [AW-1:0]    link_wdata,
    input  logic             val_we,
    input  logic [AW-1:0]    val_waddr,
    input  logic [VAL_W-1:0] val_wdata,
    output logic [AW-1:0]    rd_link,
    output logic [VAL_W-1:0] rd_value,
    output logic             ready
);

    logic [AW-1:0]    link_mem [DEPTH];
    logic [VAL_W-1:0] value_mem [DEPTH];

    logic             init_reg;
    logic             init_next;
    logic [AW-1:0]    init_addr_reg;
    logic [AW-1:0]    init_addr_next;
    logic [AW-1:0]    init_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    wr_data;

    // reset image of the link chain: free chain from entry 2, empty list at entry 1
    always_comb
    begin
        if (init_addr_reg == '0)
        begin
            init_data = AW'(2);
        end
        else if (init_addr_reg == AW'(1) || init_addr_reg == AW'(DEPTH - 1))
        begin
            init_data = '0;
        end
        else
        begin
            init_data = init_addr_reg + AW'(1);
        end
    end

    always_comb
    begin
        init_next      = init_reg;
        init_addr_next = init_addr_reg;
        if (init_reg)
        begin
            init_addr_next = init_addr_reg + AW'(1);
            if (init_addr_reg == AW'(DEPTH - 1))
            begin
                init_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b1;
            init_addr_reg <= '0;
        end
        else
        begin
            init_reg      <= init_next;
            init_addr_reg <= init_addr_next;
        end
    end

    assign wr_en   = init_reg | link_we;
    assign wr_addr = init_reg ? init_addr_reg : link_waddr;
    assign wr_data = init_reg ? init_data : link_wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_link <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_waddr] <= val_wdata;
        end
        rd_value <= value_mem[rd_addr];
    end

    assign ready = ~init_reg;

    a_no_write_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !link_we && !val_we)
        else $error("list write during clearing pass");

    a_init_stays_done: assert property (@(posedge clk) disable iff (!rst_n)
        !init_reg |=> !init_reg)
        else $error("clearing pass restarted");

    a_init_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (init_reg && init_addr_reg == AW'(DEPTH - 1)) |=> !init_reg)
        else $error("clearing pass overran");

endmodule

// ----- hdl/static_linked_list_engine.sv -----
// Linked list engine: a list of 32-bit values kept as index links in a node memory of DEPTH
// entries, at most DEPTH-2 elements. Pulse start while busy is low to transfer one request;
// exactly one result follows, shown for a single cycle with done high, and it must be taken
// then since the engine cannot be held off. A rejected insert or delete (bad position, no free
// node) reports in the cycle after the transfer. Otherwise the request walks the list one node
// per cycle through the single read port of the link memory: insert or delete walks to the
// node before position n, a find or replace stops at the first element that matches, and one
// that misses walks the whole list. After reset the link memory is loaded with its initial
// chain in a pass over all DEPTH entries, with busy held high.
module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              kind,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] new_value,
    output logic                    done,
    output logic [1:0]              status,
    output logic [IDX_W-1:0]        node_index
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam logic [AW-1:0] HEAD_NODE = AW'(1);

    state_t            state_reg;
    state_t            state_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W-1:0]  rem_next;
    logic [VAL_W-1:0]  val_reg;
    logic [VAL_W-1:0]  val_next;
    logic [VAL_W-1:0]  nval_reg;
    logic [VAL_W-1:0]  nval_next;
    logic [AW-1:0]     cur_reg;
    logic [AW-1:0]     cur_next;
    logic [AW-1:0]     prev_reg;
    logic [AW-1:0]     prev_next;
    logic [AW-1:0]     lprev_reg;
    logic [AW-1:0]     lprev_next;
    logic [AW-1:0]     free_head_reg;
    logic [AW-1:0]     free_head_next;
    logic [AW-1:0]     count_reg;
    logic [AW-1:0]     count_next;
    logic              done_reg;
    logic              done_next;
    status_t           status_reg;
    status_t           status_next;
    logic [IDX_W-1:0]  nidx_reg;
    logic [IDX_W-1:0]  nidx_next;

    logic              ready;
    logic              accept;
    kind_t             kind_in;
    logic              ins_bad;
    logic              ins_full;
    logic              del_bad;
    logic              val_match;

    logic [AW-1:0]     rd_addr;
    logic              link_we;
    logic [AW-1:0]     link_waddr;
    logic [AW-1:0]     link_wdata;
    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [VAL_W-1:0]  val_wdata;
    logic [AW-1:0]     rd_link;
    logic [VAL_W-1:0]  rd_value;

    sll_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .rd_link    (rd_link),
        .rd_value   (rd_value),
        .ready      (ready)
    );

    assign busy    = (state_reg != S_IDLE) || !ready;
    assign accept  = start && !busy;
    assign kind_in = kind_t'(kind);

    assign ins_bad   = (position == '0) || (CW'(position) > CW'(count_reg) + CW'(1));
    assign ins_full  = (free_head_reg == '0);
    assign del_bad   = (position == '0) || (CW'(position) > CW'(count_reg));
    assign val_match = (rd_value == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_in)
                        KIND_INSERT: state_next = (ins_bad || ins_full) ? S_IDLE : S_WALK;
                        KIND_DELETE: state_next = del_bad ? S_IDLE : S_WALK;
                        default:     state_next = S_WALK;
                    endcase
                end
            end
            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    case (kind_reg)
                        KIND_INSERT: state_next = S_INS_RD;
                        KIND_DELETE: state_next = (rd_link == '0) ? S_IDLE : S_DEL_RD;
                        default:     state_next = (rd_link == '0) ? S_IDLE : S_SEARCH;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (val_match || rd_link == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_RD: state_next = S_INS_WR;
            S_INS_WR: state_next = S_IDLE;
            S_DEL_RD: state_next = S_DEL_WR;
            S_DEL_WR: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        kind_next      = kind_reg;
        rem_next       = rem_reg;
        val_next       = val_reg;
        nval_next      = nval_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        lprev_next     = lprev_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        nidx_next      = nidx_reg;
        rd_addr        = rd_link;
        link_we        = 1'b0;
        link_waddr     = cur_reg;
        link_wdata     = lprev_reg;
        val_we         = 1'b0;
        val_waddr      = cur_reg;
        val_wdata      = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = HEAD_NODE;
                if (accept)
                begin
                    kind_next = kind_in;
                    val_next  = value;
                    nval_next = new_value;
                    cur_next  = HEAD_NODE;
                    rem_next  = position - POS_W'(1);
                    case (kind_in)
                        KIND_INSERT:
                        begin
                            if (ins_bad || ins_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ins_bad ? ST_BAD_POS : ST_FULL;
                                nidx_next   = '0;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (del_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_POS;
                                nidx_next   = '0;
                            end
                        end
                        default:
                        begin
                            rem_next = '0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (rem_reg != '0)
                begin
                    rd_addr  = rd_link;
                    cur_next = rd_link;
                    rem_next = rem_reg - POS_W'(1);
                end
                else
                begin
                    prev_next = cur_reg;
                    case (kind_reg)
                        KIND_INSERT:
                        begin
                            lprev_next = rd_link;
                            rd_addr    = free_head_reg;
                            cur_next   = free_head_reg;
                        end
                        KIND_DELETE:
                        begin
                            rd_addr  = rd_link;
                            cur_next = rd_link;
                            if (rd_link == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_POS;
                                nidx_next   = '0;
                            end
                        end
                        default:
                        begin
                            rd_addr  = rd_link;
                            cur_next = rd_link;
                            if (rd_link == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                                nidx_next   = '0;
                            end
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (val_match)
                begin
                    val_we      = (kind_reg == KIND_REPLACE);
                    val_waddr   = cur_reg;
                    val_wdata   = nval_reg;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    nidx_next   = IDX_W'(cur_reg);
                end
                else if (rd_link == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    nidx_next   = '0;
                end
                else
                begin
                    rd_addr  = rd_link;
                    cur_next = rd_link;
                end
            end
            S_INS_RD:
            begin
                // cur holds the free node taken for the new element
                link_we        = 1'b1;
                link_waddr     = cur_reg;
                link_wdata     = lprev_reg;
                val_we         = 1'b1;
                val_waddr      = cur_reg;
                val_wdata      = val_reg;
                free_head_next = rd_link;
                count_next     = count_reg + AW'(1);
            end
            S_INS_WR:
            begin
                link_we     = 1'b1;
                link_waddr  = prev_reg;
                link_wdata  = cur_reg;
                done_next   = 1'b1;
                status_next = ST_OK;
                nidx_next   = IDX_W'(cur_reg);
            end
            S_DEL_RD:
            begin
                // unlink the deleted node from its predecessor
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = rd_link;
            end
            S_DEL_WR:
            begin
                link_we        = 1'b1;
                link_waddr     = cur_reg;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                count_next     = count_reg - AW'(1);
                done_next      = 1'b1;
                status_next    = ST_OK;
                nidx_next      = '0;
            end
            default:
            begin
                rd_addr = HEAD_NODE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= AW'(2);
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        rem_reg    <= rem_next;
        val_reg    <= val_next;
        nval_reg   <= nval_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        lprev_reg  <= lprev_next;
        status_reg <= status_next;
        nidx_reg   <= nidx_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign node_index = nidx_reg;

    a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE) || done_reg)
        else $error("transfer neither started nor answered");

    a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (nidx_reg == '0))
        else $error("failed request carries a node index");

    a_free_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((count_reg == AW'(DEPTH - 2)) == (free_head_reg == '0)))
        else $error("free chain and element count disagree");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= AW'(DEPTH - 2))
        else $error("element count above capacity");

endmodule

// ----- bench/static_linked_list_engine_tb.sv -----
`timescale 1ns / 100ps

module static_linked_list_engine_tb;
    import sll_pkg::*;

    localparam int NODES          = DEPTH_DEF;
    localparam int MAX_ELEMS      = NODES - 2;
    localparam int FREE_HEAD      = 0;
    localparam int LIST_HEAD      = 1;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int IDLE_PERCENT   = 22;
    localparam int CALM_FIRST     = 500;
    localparam int CALM_LAST      = 800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SCRIPT_LEN     = 22;

    typedef struct packed {
        status_t          st;
        logic [IDX_W-1:0] idx;
    } list_reply_t;

    typedef struct packed {
        kind_t            k;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] nval;
        bit               typed;
        status_t          st;
        logic [IDX_W-1:0] idx;
    } request_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              kind = 2'd0;
    logic [POS_W-1:0]        position = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic signed [VAL_W-1:0] new_value = '0;
    logic                    done;
    logic [1:0]              status;
    logic [IDX_W-1:0]        node_index;

    logic [VAL_W-1:0] payload [NODES];
    logic [IDX_W-1:0] chain [NODES];
    int               elem_count;

    list_reply_t replies_due [$];
    int          mismatches = 0;
    int          stall_cycles = 0;

    request_row_t script [SCRIPT_LEN] = '{
        '{KIND_DELETE,  7'd1,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_DELETE,  7'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_FIND,    7'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 7'd0},
        '{KIND_REPLACE, 7'd0,   32'h0000_0000, 32'h0000_0005, 1'b1, ST_NOT_FOUND, 7'd0},
        '{KIND_INSERT,  7'd0,   32'h1234_5678, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_INSERT,  7'd2,   32'h1234_5678, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_INSERT,  7'd127, 32'h1234_5678, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_INSERT,  7'd1,   32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK,        7'd2},
        '{KIND_INSERT,  7'd2,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,        7'd3},
        '{KIND_INSERT,  7'd1,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,        7'd4},
        '{KIND_INSERT,  7'd2,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,        7'd5},
        '{KIND_INSERT,  7'd6,   32'h0000_0001, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_FIND,    7'd0,   32'h7FFF_FFFF, 32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{KIND_FIND,    7'd0,   32'h0000_0001, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 7'd0},
        '{KIND_REPLACE, 7'd0,   32'hFFFF_FFFF, 32'h8000_0000, 1'b0, ST_OK,        7'd0},
        '{KIND_FIND,    7'd0,   32'h8000_0000, 32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{KIND_REPLACE, 7'd127, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, ST_OK,        7'd0},
        '{KIND_DELETE,  7'd5,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_BAD_POS,   7'd0},
        '{KIND_DELETE,  7'd4,   32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{KIND_DELETE,  7'd1,   32'h0000_0000, 32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{KIND_INSERT,  7'd3,   32'h5A5A_A5A5, 32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{KIND_FIND,    7'd0,   32'h5A5A_A5A5, 32'h0000_0000, 1'b0, ST_OK,        7'd0}
    };

    static_linked_list_engine dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .new_value  (new_value),
        .done       (done),
        .status     (status),
        .node_index (node_index)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_list();
        for (int i = 0; i < NODES; i++)
        begin
            payload[i] = '0;
            chain[i]   = (i + 1 < NODES) ? IDX_W'(i + 1) : '0;
        end
        chain[FREE_HEAD] = IDX_W'(2);
        chain[LIST_HEAD] = '0;
        elem_count       = 0;
    endfunction

    function automatic logic [IDX_W-1:0] node_after(int steps);
        logic [IDX_W-1:0] cur;
        cur = IDX_W'(LIST_HEAD);
        for (int i = 0; i < steps && i < NODES; i++)
            cur = chain[cur];
        return cur;
    endfunction

    // head node is never searched
    function automatic logic [IDX_W-1:0] first_holding(logic [VAL_W-1:0] v);
        logic [IDX_W-1:0] cur;
        cur = chain[LIST_HEAD];
        for (int i = 0; i < NODES && cur != 0; i++)
        begin
            if (payload[cur] == v)
                return cur;
            cur = chain[cur];
        end
        return '0;
    endfunction

    function automatic list_reply_t apply_request(kind_t k, logic [POS_W-1:0] p,
                                                  logic [VAL_W-1:0] v, logic [VAL_W-1:0] nv);
        list_reply_t      r;
        logic [IDX_W-1:0] fresh;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] gone;
        logic [IDX_W-1:0] hit;
        r.st  = ST_OK;
        r.idx = '0;
        case (k)
            KIND_INSERT:
            begin
                fresh = chain[FREE_HEAD];
                if (p == 0 || int'(p) > elem_count + 1)
                    r.st = ST_BAD_POS;
                else if (fresh == 0)
                    r.st = ST_FULL;
                else
                begin
                    prev             = node_after(int'(p) - 1);
                    chain[FREE_HEAD] = chain[fresh];
                    payload[fresh]   = v;
                    chain[fresh]     = chain[prev];
                    chain[prev]      = fresh;
                    elem_count++;
                    r.idx = fresh;
                end
            end
            KIND_DELETE:
            begin
                if (p == 0 || int'(p) > elem_count)
                    r.st = ST_BAD_POS;
                else
                begin
                    prev = node_after(int'(p) - 1);
                    gone = chain[prev];
                    if (gone == 0)
                        r.st = ST_BAD_POS;
                    else
                    begin
                        chain[prev]      = chain[gone];
                        chain[gone]      = chain[FREE_HEAD];
                        chain[FREE_HEAD] = gone;
                        elem_count--;
                    end
                end
            end
            default:
            begin
                hit = first_holding(v);
                if (hit == 0)
                    r.st = ST_NOT_FOUND;
                else
                begin
                    if (k == KIND_REPLACE)
                        payload[hit] = nv;
                    r.idx = hit;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        if (roll < 60)
            return VAL_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    task automatic issue(kind_t k, logic [POS_W-1:0] p, logic [VAL_W-1:0] v,
                         logic [VAL_W-1:0] nv, bit typed, list_reply_t typed_reply);
        list_reply_t predicted;
        start     <= 1'b1;
        kind      <= k;
        position  <= p;
        value     <= v;
        new_value <= nv;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_request(k, p, v, nv);
        replies_due.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic pace(bit calm);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
            gap($urandom_range(1, 12));
    endtask

    task automatic random_request(bit growing);
        kind_t            k;
        logic [POS_W-1:0] p;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] nv;
        int               roll;
        roll = $urandom_range(0, 99);
        if (growing)
            k = (roll < 65) ? KIND_INSERT : (roll < 75) ? KIND_DELETE :
                (roll < 88) ? KIND_FIND : KIND_REPLACE;
        else
            k = (roll < 10) ? KIND_INSERT : (roll < 75) ? KIND_DELETE :
                (roll < 88) ? KIND_FIND : KIND_REPLACE;
        p  = POS_W'($urandom_range(0, 127));
        v  = pick_value();
        nv = pick_value();
        if (k == KIND_INSERT && $urandom_range(0, 9) != 0)
            p = POS_W'($urandom_range(1, elem_count + 1));
        if (k == KIND_DELETE && elem_count > 0 && $urandom_range(0, 9) != 0)
            p = POS_W'($urandom_range(1, elem_count));
        if ((k == KIND_FIND || k == KIND_REPLACE) && elem_count > 0
            && $urandom_range(0, 99) < 65)
            v = payload[node_after($urandom_range(1, elem_count))];
        issue(k, p, v, nv, 1'b0, '0);
    endtask

    initial
    begin
        bit growing;
        growing = 1'b1;
        clear_list();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            issue(script[i].k, script[i].pos, script[i].val, script[i].nval,
                  script[i].typed, '{script[i].st, script[i].idx});
            pace(1'b0);
        end
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (growing && elem_count == MAX_ELEMS && $urandom_range(0, 7) == 0)
                growing = 1'b0;
            else if (!growing && elem_count == 0 && $urandom_range(0, 7) == 0)
                growing = 1'b1;
            random_request(growing);
            if (n == RANDOM_ITEMS / 4)
                drain();
            else
                pace(n >= CALM_FIRST && n < CALM_LAST);
        end
        drain();
        repeat (2 * NODES) @(posedge clk);

        if (mismatches == 0)
            $display("** static_linked_list_engine: PASSED **");
        else
            $display("** static_linked_list_engine: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin : check_results
        list_reply_t want;
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result with no request pending: status %0d node_index %0d",
                       status, node_index);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    mismatches++;
                end
                if (node_index !== want.idx)
                begin
                    $error("node_index: expected %0d, actual %0d", want.idx, node_index);
                    mismatches++;
                end
            end
        end
    end

    // counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** static_linked_list_engine: FAILED **");
            $finish;
        end
    end

endmodule
